@@ design/vnth_pkg.sv @@
package vnth_pkg;

    // Octave cell sizes as shift counts: cell size is 1 << shift.
    localparam int COARSE_SHIFT = 7;
    localparam int FINE_SHIFT = 5;
    localparam int MIN_SHIFT = (COARSE_SHIFT < FINE_SHIFT) ? COARSE_SHIFT : FINE_SHIFT;
    localparam int MAX_SHIFT = (COARSE_SHIFT > FINE_SHIFT) ? COARSE_SHIFT : FINE_SHIFT;

    // Build limits and the clamp window derived from them.
    localparam int BUILD_FLOOR_Y = -64;
    localparam int BUILD_CEIL_Y = 320;
    localparam int SUM_W = 12;
    localparam logic signed [SUM_W-1:0] HEIGHT_LO = SUM_W'(BUILD_FLOOR_Y + 5);
    localparam logic signed [SUM_W-1:0] HEIGHT_HI = SUM_W'(BUILD_CEIL_Y - 2);

    // Hash constants.
    localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D049BB133111EB;
    localparam logic [63:0] FINE_SALT = 64'hD1B54A32D192ED03;

    // Depth of one hash pipeline and of the whole back end.
    localparam int MIX_LAT = 5;
    localparam int PIPE_LAT = 2 * MIX_LAT + 6;

    // Widths of cell indices, in-cell offsets and weights.
    localparam int CELL_W = 33 - MIN_SHIFT;
    localparam int FRAC_W = MAX_SHIFT;
    localparam int WGT_W = FRAC_W + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 1'b1;
    localparam logic [9:0] BASE_HEIGHT_RESET = 10'd63;

    // Cell position of one column within one octave.
    typedef struct packed {
        logic [CELL_W-1:0] cx0;
        logic [CELL_W-1:0] cx1;
        logic [CELL_W-1:0] cz0;
        logic [CELL_W-1:0] cz1;
        logic [FRAC_W-1:0] lx;
        logic [FRAC_W-1:0] lz;
    } oct_pos_t;

    // Item passed from the front end to the back end; index 0 is coarse.
    typedef struct packed {
        oct_pos_t [1:0] oct;
    } cell_item_t;

    typedef struct packed {
        logic [FRAC_W-1:0] lx;
        logic [FRAC_W-1:0] lz;
    } frac_t;

    typedef struct packed {
        logic signed [9:0] terrain_height;
        logic signed [15:0] coarse_noise;
        logic signed [15:0] fine_noise;
    } result_t;

    function automatic int oct_shift(input int oct);
        return (oct == 0) ? COARSE_SHIFT : FINE_SHIFT;
    endfunction

endpackage

@@ design/vnth_fifo.sv @@
module vnth_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop_fire;

    assign pop_fire = pop & ~empty;
    assign empty = (count_reg == '0);
    assign full = (count_reg == CNT_W'(DEPTH));
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage; a push while full is allowed only together with a pop.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop_fire})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule

@@ design/vnth_mix.sv @@
module vnth_mix (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] v_in,
    output logic [63:0] v_out
);
    import vnth_pkg::*;

    logic [63:0] v_add;
    logic [63:0] a_next, a_reg;
    logic [63:0] ll1_next, ll1_reg;
    logic [31:0] lh1_next, lh1_reg, hl1_next, hl1_reg;
    logic [63:0] prod1;
    logic [63:0] b_next, b_reg;
    logic [63:0] ll2_next, ll2_reg;
    logic [31:0] lh2_next, lh2_reg, hl2_next, hl2_reg;
    logic [63:0] prod2;
    logic [63:0] out_next, out_reg;

    // Add the golden constant, then the first xor-shift.
    assign v_add = v_in + MIX_GOLDEN;
    assign a_next = v_add ^ (v_add >> 30);

    // First multiply as three 32-bit partial products (low 64 bits only).
    assign ll1_next = a_reg[31:0] * MIX_MUL1[31:0];
    assign lh1_next = a_reg[31:0] * MIX_MUL1[63:32];
    assign hl1_next = a_reg[63:32] * MIX_MUL1[31:0];
    assign prod1 = ll1_reg + {lh1_reg + hl1_reg, 32'b0};
    assign b_next = prod1 ^ (prod1 >> 27);

    // Second multiply, same split.
    assign ll2_next = b_reg[31:0] * MIX_MUL2[31:0];
    assign lh2_next = b_reg[31:0] * MIX_MUL2[63:32];
    assign hl2_next = b_reg[63:32] * MIX_MUL2[31:0];
    assign prod2 = ll2_reg + {lh2_reg + hl2_reg, 32'b0};
    assign out_next = prod2 ^ (prod2 >> 31);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            ll1_reg <= ll1_next;
            lh1_reg <= lh1_next;
            hl1_reg <= hl1_next;
            b_reg <= b_next;
            ll2_reg <= ll2_next;
            lh2_reg <= lh2_next;
            hl2_reg <= hl2_next;
            out_reg <= out_next;
        end
    end

    assign v_out = out_reg;
endmodule

@@ design/vnth_front.sv @@
module vnth_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  z_coord,
    output vnth_pkg::cell_item_t item,
    output logic                item_valid,
    input  logic                item_take
);
    import vnth_pkg::*;

    cell_item_t col_pos;
    logic       item_empty;
    logic       push_fire;

    // Floor division by a power-of-two cell size is an arithmetic shift;
    // the offset inside the cell is the low bits.
    for (genvar o = 0; o < 2; o++)
    begin : g_oct
        localparam int SH = oct_shift(o);
        always_comb
        begin
            col_pos.oct[o].cx0 = CELL_W'(x_coord >>> SH);
            col_pos.oct[o].cz0 = CELL_W'(z_coord >>> SH);
            col_pos.oct[o].cx1 = CELL_W'(x_coord >>> SH) + 1'b1;
            col_pos.oct[o].cz1 = CELL_W'(z_coord >>> SH) + 1'b1;
            col_pos.oct[o].lx = FRAC_W'(x_coord[SH-1:0]);
            col_pos.oct[o].lz = FRAC_W'(z_coord[SH-1:0]);
        end
    end

    assign push_fire = push & ~full;

    // Short queue that decouples intake from the hash pipeline.
    vnth_fifo #(
        .DEPTH(2),
        .WIDTH($bits(cell_item_t))
    ) u_cell_q (
        .clk(clk),
        .rst_n(rst_n),
        .push(push_fire),
        .push_data(col_pos),
        .full(full),
        .pop(item_take),
        .pop_data(item),
        .empty(item_empty)
    );

    assign item_valid = ~item_empty;
endmodule

@@ design/vnth_back.sv @@
module vnth_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vnth_pkg::cell_item_t item,
    input  logic                 item_valid,
    output logic                 item_take,
    input  logic [63:0]          world_seed,
    input  logic signed [9:0]    base_height,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [9:0]    terrain_height,
    output logic signed [15:0]   coarse_noise,
    output logic signed [15:0]   fine_noise
);
    import vnth_pkg::*;

    localparam int PW_W = 16 + WGT_W + 1;
    localparam int EDGE_W = 16 + WGT_W;
    localparam int PROD_W = EDGE_W + WGT_W + 1;
    localparam int ACC_W = 16 + 2 * FRAC_W + 2;

    logic                run;
    logic                out_full;
    logic                out_push;
    logic [PIPE_LAT-1:0] valid_reg;
    logic [63:0]         oct_seed [2];
    logic [63:0]         lat_in [2][4];
    logic [63:0]         lat_out [2][4];
    logic [63:0]         cor_in [2][4];
    logic [63:0]         cor_out [2][4];
    frac_t [1:0]         frac_dly_reg [2*MIX_LAT];
    logic signed [15:0]  noise [2];
    logic signed [15:0]  coarse_h0_reg, fine_h0_reg;
    logic signed [21:0]  coarse30_reg;
    logic signed [20:0]  fine9_reg;
    logic signed [21:0]  coarse_q;
    logic signed [20:0]  fine_q;
    logic signed [SUM_W-1:0] height_sum;
    logic signed [SUM_W-1:0] height_clamp;
    result_t             result_reg;
    result_t             out_item;

    // The whole pipeline moves only when its last stage can drain.
    assign run = ~out_full | (pop & ~empty);
    assign item_take = run & item_valid;
    assign out_push = run & valid_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (run)
        begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], item_valid};
        end
    end

    assign oct_seed[0] = world_seed;
    assign oct_seed[1] = world_seed ^ FINE_SALT;

    // Offsets ride alongside the two hash rounds.
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            for (int s = 2 * MIX_LAT - 1; s > 0; s--)
            begin
                frac_dly_reg[s] <= frac_dly_reg[s-1];
            end
            for (int o = 0; o < 2; o++)
            begin
                frac_dly_reg[0][o].lx <= item.oct[o].lx;
                frac_dly_reg[0][o].lz <= item.oct[o].lz;
            end
        end
    end

    for (genvar o = 0; o < 2; o++)
    begin : g_oct
        localparam int SH = oct_shift(o);
        localparam logic [WGT_W-1:0] SCALE = WGT_W'(1 << SH);
        localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << (2 * SH)) - 1);

        logic signed [15:0]       cval [4];
        logic [WGT_W-1:0]         wx [2];
        logic signed [PW_W-1:0]   pw_reg [4];
        logic [FRAC_W-1:0]        lz_i0_reg, lz_i1_reg;
        logic signed [EDGE_W-1:0] top_reg, bot_reg;
        logic [WGT_W-1:0]         wz0, wz1;
        logic signed [PROD_W-1:0] pt_reg, pb_reg;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  quo;
        logic signed [15:0]       noise_reg;

        // Lattice hashes of the two column and two row indices.
        assign lat_in[o][0] = {{(64 - CELL_W){item.oct[o].cx0[CELL_W-1]}}, item.oct[o].cx0};
        assign lat_in[o][1] = {{(64 - CELL_W){item.oct[o].cx1[CELL_W-1]}}, item.oct[o].cx1};
        assign lat_in[o][2] = {{(64 - CELL_W){item.oct[o].cz0[CELL_W-1]}}, item.oct[o].cz0};
        assign lat_in[o][3] = {{(64 - CELL_W){item.oct[o].cz1[CELL_W-1]}}, item.oct[o].cz1};

        for (genvar k = 0; k < 4; k++)
        begin : g_corner
            vnth_mix u_lat_mix (
                .clk(clk),
                .en(run),
                .v_in(lat_in[o][k]),
                .v_out(lat_out[o][k])
            );

            // Corner k: column index k%2, row index k/2.
            assign cor_in[o][k] = oct_seed[o] ^ lat_out[o][k % 2]
                                ^ {lat_out[o][2 + k / 2][62:0], 1'b0};

            vnth_mix u_cor_mix (
                .clk(clk),
                .en(run),
                .v_in(cor_in[o][k]),
                .v_out(cor_out[o][k])
            );

            // Low 16 bits minus 32768 is the same word with its top bit flipped.
            assign cval[k] = {~cor_out[o][k][15], cor_out[o][k][14:0]};
        end

        assign wx[1] = WGT_W'(frac_dly_reg[2*MIX_LAT-1][o].lx);
        assign wx[0] = SCALE - wx[1];
        assign wz1 = WGT_W'(lz_i1_reg);
        assign wz0 = SCALE - wz1;

        // Interpolation: weight the corners, sum along x, weight along z, divide.
        assign acc = ACC_W'(pt_reg + pb_reg);
        assign quo = (acc + (acc[ACC_W-1] ? ROUND_BIAS : '0)) >>> (2 * SH);

        always_ff @(posedge clk)
        begin
            if (run)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    pw_reg[k] <= cval[k] * $signed({1'b0, wx[k % 2]});
                end
                lz_i0_reg <= frac_dly_reg[2*MIX_LAT-1][o].lz;
                top_reg <= EDGE_W'(pw_reg[0] + pw_reg[1]);
                bot_reg <= EDGE_W'(pw_reg[2] + pw_reg[3]);
                lz_i1_reg <= lz_i0_reg;
                pt_reg <= top_reg * $signed({1'b0, wz0});
                pb_reg <= bot_reg * $signed({1'b0, wz1});
                noise_reg <= quo[15:0];
            end
        end

        assign noise[o] = noise_reg;
    end

    // Height: scale both octaves, truncate toward zero, add the base height, clamp.
    assign coarse_q = (coarse30_reg + (coarse30_reg[21] ? 22'sd32767 : 22'sd0)) >>> 15;
    assign fine_q = (fine9_reg + (fine9_reg[20] ? 21'sd32767 : 21'sd0)) >>> 15;
    assign height_sum = SUM_W'(base_height) + SUM_W'(coarse_q) + SUM_W'(fine_q);

    always_comb
    begin
        priority if (height_sum < HEIGHT_LO)
        begin
            height_clamp = HEIGHT_LO;
        end
        else if (height_sum > HEIGHT_HI)
        begin
            height_clamp = HEIGHT_HI;
        end
        else
        begin
            height_clamp = height_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            coarse30_reg <= noise[0] * 6'sd30;
            fine9_reg <= noise[1] * 5'sd9;
            coarse_h0_reg <= noise[0];
            fine_h0_reg <= noise[1];
            result_reg.terrain_height <= height_clamp[9:0];
            result_reg.coarse_noise <= coarse_h0_reg;
            result_reg.fine_noise <= fine_h0_reg;
        end
    end

    // Result queue towards the consumer.
    vnth_fifo #(
        .DEPTH(2),
        .WIDTH($bits(result_t))
    ) u_result_q (
        .clk(clk),
        .rst_n(rst_n),
        .push(out_push),
        .push_data(result_reg),
        .full(out_full),
        .pop(pop),
        .pop_data(out_item),
        .empty(empty)
    );

    assign terrain_height = out_item.terrain_height;
    assign coarse_noise = out_item.coarse_noise;
    assign fine_noise = out_item.fine_noise;
endmodule

@@ design/value_noise_terrain_height_top.sv @@
// Channel   Handshake                  Payload
// input     push / full                x_coord, z_coord
// result    empty / pop                terrain_height, coarse_noise, fine_noise
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item is accepted per cycle while full is low; on its way to a result each
// item passes the input queue, two chained 5-stage hash pipelines, four
// interpolation stages and two height stages.
// Reset clears the queues and the valid bits; world_seed resets to 0 and
// the base height to 63. A full result queue stalls the whole pipeline; the input
// queue then fills and raises full.
module value_noise_terrain_height_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [31:0]                     x_coord,
    input  logic signed [31:0]                     z_coord,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [9:0]                      terrain_height,
    output logic signed [15:0]                     coarse_noise,
    output logic signed [15:0]                     fine_noise,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vnth_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [63:0]                            cfg_data
);
    import vnth_pkg::*;

    logic [63:0] world_seed_reg;
    logic [9:0]  base_height_reg;
    cell_item_t  item;
    logic        item_valid;
    logic        item_take;

    // Configuration registers; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_seed_reg <= '0;
            base_height_reg <= BASE_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WORLD_SEED:  world_seed_reg <= cfg_data;
                REG_BASE_HEIGHT: base_height_reg <= cfg_data[9:0];
                default:         world_seed_reg <= world_seed_reg;
            endcase
        end
    end

    vnth_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .x_coord(x_coord),
        .z_coord(z_coord),
        .item(item),
        .item_valid(item_valid),
        .item_take(item_take)
    );

    vnth_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .item_valid(item_valid),
        .item_take(item_take),
        .world_seed(world_seed_reg),
        .base_height(base_height_reg),
        .empty(empty),
        .pop(pop),
        .terrain_height(terrain_height),
        .coarse_noise(coarse_noise),
        .fine_noise(fine_noise)
    );
endmodule
